// File: rtl/fip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fip_pkg
// Shared constants, datapath operation codes and control structs for the
// Feistel index permuter.
// ----------------------------------------------------------------------------
package fip_pkg;

    localparam int IDX_W    = 32;
    localparam int CNT_W    = 31;
    localparam int RANK_W   = 30;
    localparam int HALF_MAX = 15;
    localparam int HALF_W   = 4;
    localparam int DIV_W    = 5;
    localparam int OP_W     = 4;

    localparam int DEF_MAX_WALKS      = 64;
    localparam int DEF_FEISTEL_ROUNDS = 4;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = 31'h4000_0000;
    localparam logic [31:0]      HASH_C1     = 32'h7FEB_352D;
    localparam logic [31:0]      HASH_C2     = 32'h846C_A68B;
    localparam logic [31:0]      ROUND_STEP  = 32'h9E37_79B9;

    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd2;
    localparam logic [OP_W-1:0] OP_START    = 4'd3;
    localparam logic [OP_W-1:0] OP_SPLIT    = 4'd4;
    localparam logic [OP_W-1:0] OP_H0       = 4'd5;
    localparam logic [OP_W-1:0] OP_H1       = 4'd6;
    localparam logic [OP_W-1:0] OP_H2       = 4'd7;
    localparam logic [OP_W-1:0] OP_H3       = 4'd8;
    localparam logic [OP_W-1:0] OP_JOIN     = 4'd9;
    localparam logic [OP_W-1:0] OP_SET_EXH  = 4'd10;
    localparam logic [OP_W-1:0] OP_SET_OK   = 4'd11;
    localparam logic [OP_W-1:0] OP_SET_ZERO = 4'd12;
    localparam logic [OP_W-1:0] OP_PUSH     = 4'd13;

    typedef struct packed {
        logic            en;
        logic [OP_W-1:0] op;
    } ctrl_t;

    typedef struct packed {
        logic count_low;
        logic div_more;
        logic round_more;
        logic in_range;
        logic walk_more;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/feistel_index_permuter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feistel_index_permuter
// Maps an index to a pseudo-random rank below item_count by a cycle-walked
// Feistel network, under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A count below 2 skips the divider
// and gives rank zero. Otherwise the index is reduced by a restoring divider
// at one quotient bit per cycle, then each walk pass splits the value, runs
// FEISTEL_ROUNDS rounds of the hash steps H0 to H3 and joins the halves,
// until the value lies below the count or MAX_WALKS passes are spent; an
// exhausted walk returns the reduced start value. The next transaction is
// taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module feistel_index_permuter #(
    parameter int MAX_WALKS      = fip_pkg::DEF_MAX_WALKS,
    parameter int FEISTEL_ROUNDS = fip_pkg::DEF_FEISTEL_ROUNDS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [fip_pkg::CNT_W-1:0] cfg_wr_data,  // item_count
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [31:0]               s_tdata,      // [31:0] index
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [31:0]                    m_tdata,      // [29:0] rank, [31:30] zero
    output logic                           m_tuser       // [0] walk_exhausted
);
    import fip_pkg::*;

    ctrl_t             ctrl;
    status_t           status;
    logic              out_free;
    logic [RANK_W-1:0] rank;

    assign out_free = !m_tvalid || m_tready;

    fip_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    fip_datapath #(
        .MAX_WALKS      (MAX_WALKS),
        .FEISTEL_ROUNDS (FEISTEL_ROUNDS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .in_index    (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_rank    (rank),
        .out_exh     (m_tuser),
        .status      (status)
    );

    assign m_tdata = {2'b00, rank};

endmodule
`default_nettype wire

// File: rtl/fip_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fip_sequencer
// Step counter and microcode ROM. Each step issues one datapath operation,
// optionally waits on a handshake, and may branch always or on a datapath status bit.
// ----------------------------------------------------------------------------
module fip_sequencer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic            out_free,
    input  wire fip_pkg::status_t status,
    output fip_pkg::ctrl_t       ctrl,
    output logic                 in_ready
);
    import fip_pkg::*;

    localparam int PC_W = 4;

    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_IN   = 2'd1;
    localparam logic [1:0] W_OUT  = 2'd2;

    localparam logic [2:0] J_NONE   = 3'd0;
    localparam logic [2:0] J_ALWAYS = 3'd1;
    localparam logic [2:0] J_SMALL  = 3'd2;
    localparam logic [2:0] J_DIV    = 3'd3;
    localparam logic [2:0] J_ROUND  = 3'd4;
    localparam logic [2:0] J_RANGE  = 3'd5;
    localparam logic [2:0] J_WALK   = 3'd6;

    localparam logic [PC_W-1:0] S_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] S_CHECK = 4'd1;
    localparam logic [PC_W-1:0] S_DIV   = 4'd2;
    localparam logic [PC_W-1:0] S_START = 4'd3;
    localparam logic [PC_W-1:0] S_SPLIT = 4'd4;
    localparam logic [PC_W-1:0] S_H0    = 4'd5;
    localparam logic [PC_W-1:0] S_H1    = 4'd6;
    localparam logic [PC_W-1:0] S_H2    = 4'd7;
    localparam logic [PC_W-1:0] S_H3    = 4'd8;
    localparam logic [PC_W-1:0] S_JOIN  = 4'd9;
    localparam logic [PC_W-1:0] S_RANGE = 4'd10;
    localparam logic [PC_W-1:0] S_WALK  = 4'd11;
    localparam logic [PC_W-1:0] S_EXH   = 4'd12;
    localparam logic [PC_W-1:0] S_OK    = 4'd13;
    localparam logic [PC_W-1:0] S_ZERO  = 4'd14;
    localparam logic [PC_W-1:0] S_EMIT  = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      wait_on;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } uword_t;

    function automatic uword_t rom(input logic [PC_W-1:0] a);
        uword_t w;
        unique case (a)
            S_WAIT:  w = '{OP_LOAD,     W_IN,   J_NONE,   S_WAIT};
            S_CHECK: w = '{OP_NOP,      W_NONE, J_SMALL,  S_ZERO};
            S_DIV:   w = '{OP_DIV,      W_NONE, J_DIV,    S_DIV};
            S_START: w = '{OP_START,    W_NONE, J_NONE,   S_WAIT};
            S_SPLIT: w = '{OP_SPLIT,    W_NONE, J_NONE,   S_WAIT};
            S_H0:    w = '{OP_H0,       W_NONE, J_NONE,   S_WAIT};
            S_H1:    w = '{OP_H1,       W_NONE, J_NONE,   S_WAIT};
            S_H2:    w = '{OP_H2,       W_NONE, J_NONE,   S_WAIT};
            S_H3:    w = '{OP_H3,       W_NONE, J_ROUND,  S_H0};
            S_JOIN:  w = '{OP_JOIN,     W_NONE, J_NONE,   S_WAIT};
            S_RANGE: w = '{OP_NOP,      W_NONE, J_RANGE,  S_OK};
            S_WALK:  w = '{OP_NOP,      W_NONE, J_WALK,   S_SPLIT};
            S_EXH:   w = '{OP_SET_EXH,  W_NONE, J_ALWAYS, S_EMIT};
            S_OK:    w = '{OP_SET_OK,   W_NONE, J_ALWAYS, S_EMIT};
            S_ZERO:  w = '{OP_SET_ZERO, W_NONE, J_NONE,   S_WAIT};
            S_EMIT:  w = '{OP_PUSH,     W_OUT,  J_ALWAYS, S_WAIT};
            default: w = '{OP_NOP,      W_NONE, J_ALWAYS, S_WAIT};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            en;
    logic            take;

    always_comb begin
        uw = rom(pc_reg);
        unique case (uw.wait_on)
            W_IN:    en = in_valid;
            W_OUT:   en = out_free;
            default: en = 1'b1;
        endcase
        unique case (uw.cond)
            J_ALWAYS: take = 1'b1;
            J_SMALL:  take = status.count_low;
            J_DIV:    take = status.div_more;
            J_ROUND:  take = status.round_more;
            J_RANGE:  take = status.in_range;
            J_WALK:   take = status.walk_more;
            default:  take = 1'b0;
        endcase
        if (!en) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.en  = en;
    assign ctrl.op  = uw.op;
    assign in_ready = (uw.wait_on == W_IN);

endmodule
`default_nettype wire

// File: rtl/fip_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fip_datapath
// Count register, restoring modulo unit, Feistel half registers, hash
// pipeline registers, walk/round counters and the output register.
// ----------------------------------------------------------------------------
module fip_datapath #(
    parameter int MAX_WALKS      = fip_pkg::DEF_MAX_WALKS,
    parameter int FEISTEL_ROUNDS = fip_pkg::DEF_FEISTEL_ROUNDS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire fip_pkg::ctrl_t             ctrl,
    input  wire logic [fip_pkg::IDX_W-1:0]  in_index,
    input  wire logic                       cfg_wr_en,
    input  wire logic [fip_pkg::CNT_W-1:0]  cfg_wr_data,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [fip_pkg::RANK_W-1:0]      out_rank,
    output logic                            out_exh,
    output fip_pkg::status_t                status
);
    import fip_pkg::*;

    localparam int RND_W  = (FEISTEL_ROUNDS > 1) ? $clog2(FEISTEL_ROUNDS) : 1;
    localparam int WALK_W = $clog2(MAX_WALKS + 1);

    function automatic logic [HALF_W-1:0] half_of(input logic [CNT_W-1:0] c);
        logic [HALF_W-1:0] r;
        r = HALF_W'(HALF_MAX);
        for (int h = HALF_MAX; h >= 1; h--) begin
            if ({1'b0, c} <= (32'd1 << (2 * h))) begin
                r = HALF_W'(h);
            end
        end
        return r;
    endfunction

    logic [CNT_W-1:0]    cnt_reg;
    logic [HALF_W-1:0]   half_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [RANK_W-1:0]   rem_reg;
    logic [DIV_W-1:0]    div_cnt_reg;
    logic [RANK_W-1:0]   start_reg;
    logic [RANK_W-1:0]   v_reg;
    logic [HALF_MAX-1:0] left_reg;
    logic [HALF_MAX-1:0] right_reg;
    logic [31:0]         h_reg;
    logic [31:0]         key_reg;
    logic [RND_W-1:0]    rnd_reg;
    logic [WALK_W-1:0]   walk_reg;
    logic [RANK_W-1:0]   res_reg;
    logic                res_exh_reg;
    logic                out_valid_reg;
    logic [RANK_W-1:0]   out_rank_reg;
    logic                out_exh_reg;

    logic [CNT_W-1:0]    cfg_sat;
    logic [CNT_W-1:0]    trial;
    logic [HALF_MAX-1:0] mask;
    logic [31:0]         h0_val;
    logic [31:0]         h2_val;
    logic [31:0]         h3_val;

    always_comb begin
        cfg_sat = (cfg_wr_data > COUNT_LIMIT) ? COUNT_LIMIT : cfg_wr_data;
        trial   = {rem_reg, idx_reg[IDX_W-1]};
        mask    = HALF_MAX'((16'd1 << half_reg) - 16'd1);
        h0_val  = {17'd0, right_reg} + key_reg;
        h0_val  = h0_val ^ (h0_val >> 16);
        h2_val  = h_reg ^ (h_reg >> 15);
        h3_val  = h_reg ^ (h_reg >> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= CNT_W'(1);
            half_reg <= HALF_W'(1);
        end else if (cfg_wr_en) begin
            cnt_reg  <= cfg_sat;
            half_reg <= half_of(cfg_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            unique case (ctrl.op)
                OP_LOAD: begin
                    idx_reg     <= in_index;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                end
                OP_DIV: begin
                    idx_reg     <= {idx_reg[IDX_W-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (trial >= cnt_reg) begin
                        rem_reg <= RANK_W'(trial - cnt_reg);
                    end else begin
                        rem_reg <= RANK_W'(trial);
                    end
                end
                OP_START: begin
                    start_reg <= rem_reg;
                    v_reg     <= rem_reg;
                    walk_reg  <= '0;
                end
                OP_SPLIT: begin
                    left_reg  <= HALF_MAX'(v_reg >> half_reg) & mask;
                    right_reg <= v_reg[HALF_MAX-1:0] & mask;
                    key_reg   <= '0;
                    rnd_reg   <= '0;
                end
                OP_H0: h_reg <= h0_val;
                OP_H1: h_reg <= 32'(h_reg * HASH_C1);
                OP_H2: h_reg <= 32'(h2_val * HASH_C2);
                OP_H3: begin
                    right_reg <= left_reg ^ (h3_val[HALF_MAX-1:0] & mask);
                    left_reg  <= right_reg;
                    key_reg   <= key_reg + ROUND_STEP;
                    rnd_reg   <= rnd_reg + 1'b1;
                end
                OP_JOIN: begin
                    v_reg    <= (RANK_W'(left_reg) << half_reg) | RANK_W'(right_reg);
                    walk_reg <= walk_reg + 1'b1;
                end
                OP_SET_EXH: begin
                    res_reg     <= start_reg;
                    res_exh_reg <= 1'b1;
                end
                OP_SET_OK: begin
                    res_reg     <= v_reg;
                    res_exh_reg <= 1'b0;
                end
                OP_SET_ZERO: begin
                    res_reg     <= '0;
                    res_exh_reg <= 1'b0;
                end
                OP_PUSH: begin
                    out_rank_reg <= res_reg;
                    out_exh_reg  <= res_exh_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.en && ctrl.op == OP_PUSH) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.count_low  = (cnt_reg < CNT_W'(2));
    assign status.div_more   = (div_cnt_reg != DIV_W'(IDX_W - 1));
    assign status.round_more = (rnd_reg != RND_W'(FEISTEL_ROUNDS - 1));
    assign status.in_range   = ({1'b0, v_reg} < cnt_reg);
    assign status.walk_more  = (walk_reg != WALK_W'(MAX_WALKS));

    assign out_valid = out_valid_reg;
    assign out_rank  = out_rank_reg;
    assign out_exh   = out_exh_reg;

endmodule
`default_nettype wire

// File: rtl/fip_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fip_checker
// Port-level checks for the Feistel index permuter, bound to the top level.
// ----------------------------------------------------------------------------
module fip_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      cfg_wr_en,
    input wire logic [fip_pkg::CNT_W-1:0] cfg_wr_data,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic [31:0]               s_tdata,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [31:0]               m_tdata,
    input wire logic                      m_tuser
);
    import fip_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cfg_sat;

    assign cfg_sat = (cfg_wr_data > COUNT_LIMIT) ? COUNT_LIMIT : cfg_wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNT_W'(1);
        end else if (cfg_wr_en) begin
            cnt_reg <= cfg_sat;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cnt_reg >= CNT_W'(2) |-> {1'b0, m_tdata[29:0]} < cnt_reg
            && m_tdata[31:30] == 2'b00)
        else $error("rank outside the permuted range");

    a_small_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cnt_reg < CNT_W'(2) |-> m_tdata == 32'd0 && !m_tuser)
        else $error("small count must give rank zero");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken before the first finished");

endmodule

bind feistel_index_permuter fip_checker u_fip_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
);
`default_nettype wire
